// ----- src/chained_hash_count_table_macros.svh -----
// Assertion macros used by the checker file.
`ifndef CHAINED_HASH_COUNT_TABLE_MACROS_SVH
`define CHAINED_HASH_COUNT_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHCT_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
		else $error("chct: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHCT_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error("chct: next-cycle check failed");

`endif

// ----- src/chct_pkg.sv -----
package chct_pkg;

	// BUCKETS must be a power of two: the bucket is the low bits of the magnitude.
	localparam int BUCKETS   = 1024;
	localparam int ENTRIES   = 4096;
	localparam int BUCKET_W  = $clog2(BUCKETS);
	localparam int ENTRY_W   = $clog2(ENTRIES);
	localparam int FREE_W    = $clog2(ENTRIES + 1);
	localparam int KEY_W     = 32;
	localparam int COUNT_W   = 32;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	typedef struct packed {
		logic                head_re;
		logic [BUCKET_W-1:0] head_raddr;
		logic                head_we;
		logic [BUCKET_W-1:0] head_waddr;
		logic [ENTRY_W-1:0]  head_wdata;
		logic                ent_re;
		logic [ENTRY_W-1:0]  ent_raddr;
		logic                ent_we_all;
		logic                ent_we_cnt;
		logic [ENTRY_W-1:0]  ent_waddr;
		logic [KEY_W-1:0]    ent_wkey;
		logic [COUNT_W-1:0]  ent_wcount;
		logic [ENTRY_W-1:0]  ent_wlink;
		logic                ent_wlink_valid;
	} mem_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]  head_idx;
		logic [KEY_W-1:0]    ent_key;
		logic [COUNT_W-1:0]  ent_count;
		logic [ENTRY_W-1:0]  ent_link;
		logic                ent_link_valid;
	} mem_rsp_t;

	typedef struct packed {
		logic [BUCKET_W-1:0] bucket;
		logic                match;
		logic                same_bucket;
		logic [COUNT_W-1:0]  count_inc;
	} unit_res_t;

endpackage

// ----- src/chct_unit.sv -----
module chct_unit
	import chct_pkg::*;
(
	input  logic [KEY_W-1:0]    hash_key,
	input  logic [BUCKET_W-1:0] bucket_ref,
	input  logic [KEY_W-1:0]    search_key,
	input  logic [KEY_W-1:0]    ent_key,
	input  logic [COUNT_W-1:0]  ent_count,
	output unit_res_t           res
);

	logic [KEY_W-1:0] mag;

	// Magnitude of the key as unsigned; the most negative key maps to 2^31.
	assign mag = hash_key[KEY_W-1] ? (~hash_key + KEY_W'(1)) : hash_key;

	always_comb begin
		res.bucket      = mag[BUCKET_W-1:0];
		res.same_bucket = (mag[BUCKET_W-1:0] == bucket_ref);
		res.match       = (ent_key == search_key);
		res.count_inc   = (ent_count == COUNT_MAX) ? COUNT_MAX : (ent_count + COUNT_W'(1));
	end

endmodule

// ----- src/chct_mem.sv -----
module chct_mem
	import chct_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output mem_rsp_t rsp
);

	logic [ENTRY_W-1:0] head_mem  [BUCKETS];
	logic [KEY_W-1:0]   key_mem   [ENTRIES];
	logic [COUNT_W-1:0] count_mem [ENTRIES];
	logic [ENTRY_W:0]   link_mem  [ENTRIES];

	logic [ENTRY_W-1:0] head_rd_q;
	logic [KEY_W-1:0]   key_rd_q;
	logic [COUNT_W-1:0] count_rd_q;
	logic [ENTRY_W:0]   link_rd_q;

	always_ff @(posedge clk) begin
		if (req.head_we) begin
			head_mem[req.head_waddr] <= req.head_wdata;
		end
		if (req.head_re) begin
			head_rd_q <= head_mem[req.head_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.ent_we_all) begin
			key_mem[req.ent_waddr] <= req.ent_wkey;
		end
		if (req.ent_re) begin
			key_rd_q <= key_mem[req.ent_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.ent_we_all || req.ent_we_cnt) begin
			count_mem[req.ent_waddr] <= req.ent_wcount;
		end
		if (req.ent_re) begin
			count_rd_q <= count_mem[req.ent_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (req.ent_we_all) begin
			link_mem[req.ent_waddr] <= {req.ent_wlink_valid, req.ent_wlink};
		end
		if (req.ent_re) begin
			link_rd_q <= link_mem[req.ent_raddr];
		end
	end

	always_comb begin
		rsp.head_idx       = head_rd_q;
		rsp.ent_key        = key_rd_q;
		rsp.ent_count      = count_rd_q;
		rsp.ent_link       = link_rd_q[ENTRY_W-1:0];
		rsp.ent_link_valid = link_rd_q[ENTRY_W];
	end

endmodule

// ----- src/chained_hash_count_table.sv -----
// Channel   Direction  tdata            tuser
// s_axis    in         key[31:0]        kind[1:0]
// m_axis    out        count[31:0]      found[0], pool_full[1]
//
// Clear and the unused kind go from accept straight to a waiting result; insert
// and query first read the bucket head, then visit chain entries, each costing one
// registered read of the entry pool, and take one more step on a miss.
// The input is not ready from an accepted beat until its result moves into the
// output register, so a stalled output holds the block once a second result is ready.
// After reset the head memory is swept once over all BUCKETS (1024) heads, input not ready.
module chained_hash_count_table
	import chct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // key[31:0]
	input  logic [1:0]  s_axis_tuser,   // kind[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // count[31:0]
	output logic [1:0]  m_axis_tuser    // found[0], pool_full[1]
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_HEAD  = 6'b000010,
		ST_ENTRY = 6'b000100,
		ST_MISS  = 6'b001000,
		ST_DONE  = 6'b010000,
		ST_INIT  = 6'b100000
	} state_t;

	state_t              state_q;
	logic [BUCKET_W-1:0] init_q;
	logic [1:0]          kind_q;
	logic [KEY_W-1:0]    key_q;
	logic [BUCKET_W-1:0] bucket_q;
	logic [ENTRY_W-1:0]  head_q;
	logic                head_ok_q;
	logic                chk_head_q;
	logic [ENTRY_W-1:0]  cur_q;
	logic [FREE_W-1:0]   next_free_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic                res_found_q;
	logic                res_full_q;
	logic                out_valid_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic                out_found_q;
	logic                out_full_q;

	mem_req_t  req;
	mem_rsp_t  rsp;
	unit_res_t ures;

	logic accept;
	logic lookup_kind;
	logic head_live;
	logic stale;
	logic hit;
	logic walk_on;
	logic room;
	logic out_free;

	// The one hash/compare/increment unit: it hashes the incoming key while idle,
	// and the key of the entry just read while walking a chain.
	chct_unit u_unit (
		.hash_key  ((state_q == ST_IDLE) ? s_axis_tdata : rsp.ent_key),
		.bucket_ref(bucket_q),
		.search_key(key_q),
		.ent_key   (rsp.ent_key),
		.ent_count (rsp.ent_count),
		.res       (ures)
	);

	chct_mem u_mem (
		.clk(clk),
		.req(req),
		.rsp(rsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign lookup_kind   = (s_axis_tuser == KIND_INSERT) || (s_axis_tuser == KIND_QUERY);

	// A clear beat leaves the head memory alone. A head is trusted only if it points
	// below the allocator and the entry there hashes to this bucket: an entry taken
	// since the last clear for this bucket would have rewritten the head.
	assign head_live = {1'b0, rsp.head_idx} < next_free_q;
	assign stale     = chk_head_q && !ures.same_bucket;
	assign hit       = !stale && ures.match;
	assign walk_on   = !stale && !ures.match && rsp.ent_link_valid;
	assign room      = next_free_q < FREE_W'(ENTRIES);
	assign out_free  = !out_valid_q || m_axis_tready;

	always_comb begin
		req = '0;
		case (state_q)
			ST_INIT: begin
				// Give every head a defined value once after reset.
				req.head_we    = 1'b1;
				req.head_waddr = init_q;
				req.head_wdata = '0;
			end
			ST_IDLE: begin
				req.head_re    = accept && lookup_kind;
				req.head_raddr = ures.bucket;
			end
			ST_HEAD: begin
				req.ent_re    = head_live;
				req.ent_raddr = rsp.head_idx;
			end
			ST_ENTRY: begin
				req.ent_re     = walk_on;
				req.ent_raddr  = rsp.ent_link;
				req.ent_we_cnt = hit && (kind_q == KIND_INSERT);
				req.ent_waddr  = cur_q;
				req.ent_wcount = ures.count_inc;
			end
			ST_MISS: begin
				// On an insert with room, allocate the next pool entry and link it in front of the chain.
				req.ent_we_all      = (kind_q == KIND_INSERT) && room;
				req.ent_waddr       = next_free_q[ENTRY_W-1:0];
				req.ent_wkey        = key_q;
				req.ent_wcount      = COUNT_W'(1);
				req.ent_wlink       = head_q;
				req.ent_wlink_valid = head_ok_q;
				req.head_we         = (kind_q == KIND_INSERT) && room;
				req.head_waddr      = bucket_q;
				req.head_wdata      = next_free_q[ENTRY_W-1:0];
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			next_free_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + BUCKET_W'(1);
					if (init_q == BUCKET_W'(BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser == KIND_CLEAR) begin
							next_free_q <= '0;
						end
						state_q <= lookup_kind ? ST_HEAD : ST_DONE;
					end
				end
				ST_HEAD: begin
					state_q <= head_live ? ST_ENTRY : ST_MISS;
				end
				ST_ENTRY: begin
					if (hit) begin
						state_q <= ST_DONE;
					end else if (!walk_on) begin
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					if ((kind_q == KIND_INSERT) && room) begin
						next_free_q <= next_free_q + FREE_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item context and result; payload only, so no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q      <= s_axis_tuser;
					key_q       <= s_axis_tdata;
					bucket_q    <= ures.bucket;
					res_count_q <= '0;
					res_found_q <= 1'b0;
					res_full_q  <= 1'b0;
				end
			end
			ST_HEAD: begin
				head_q     <= rsp.head_idx;
				cur_q      <= rsp.head_idx;
				head_ok_q  <= 1'b0;
				chk_head_q <= 1'b1;
			end
			ST_ENTRY: begin
				if (chk_head_q && !stale) begin
					head_ok_q <= 1'b1;
				end
				chk_head_q <= 1'b0;
				cur_q      <= rsp.ent_link;
				if (hit) begin
					res_found_q <= 1'b1;
					res_count_q <= (kind_q == KIND_INSERT) ? ures.count_inc : rsp.ent_count;
				end
			end
			ST_MISS: begin
				if (kind_q == KIND_INSERT) begin
					res_count_q <= room ? COUNT_W'(1) : '0;
					res_full_q  <= !room;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_count_q <= res_count_q;
					out_found_q <= res_found_q;
					out_full_q  <= res_full_q;
				end
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_count_q;
	assign m_axis_tuser  = {out_full_q, out_found_q};

endmodule

// ----- src/chct_checker.sv -----
`include "chained_hash_count_table_macros.svh"

module chct_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	logic        in_beat;
	logic        full_shown;
	logic        full_quiet;
	logic        found_shown;
	logic        out_stall;
	logic [33:0] out_word;

	assign in_beat     = s_axis_tvalid && s_axis_tready;
	assign full_shown  = m_axis_tvalid && m_axis_tuser[1];
	assign full_quiet  = (m_axis_tdata == 32'd0) && !m_axis_tuser[0];
	assign found_shown = m_axis_tvalid && m_axis_tuser[0];
	assign out_stall   = m_axis_tvalid && !m_axis_tready;
	assign out_word    = {m_axis_tuser, m_axis_tdata};

	// A dropped insert reports nothing else.
	`CHCT_ASSERT_NOW(a_full_alone, clk, arst_n, full_shown, full_quiet)

	// A key that was found always has a stored count of at least one.
	`CHCT_ASSERT_NOW(a_found_nonzero, clk, arst_n, found_shown, m_axis_tdata != 32'd0)

	// One item at a time: the input closes right after a beat is taken.
	`CHCT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_beat, !s_axis_tready)

	// A result beat that is not taken holds its value.
	`CHCT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind chained_hash_count_table chct_checker u_chct_checker (.*);

// ----- dv/chained_hash_count_table_test.sv -----
`timescale 1ns / 100ps

module chained_hash_count_table_test
	import chct_pkg::*;
();

	// Kind code that the block must ignore; the package only names the three used ones.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int IDLE_PCT     = 25;
	localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
	localparam int QUIET_LIMIT  = 20000;  // cycles with no beat on either side
	localparam int TAIL_CYCLES  = 64;     // covers the longest chain walk seen in the run
	localparam int MAX_REPORTS  = 40;
	localparam int CHAIN_BUCKET = 7;
	localparam int CHAIN_PAIRS  = 24;     // two keys per magnitude: 48 entries in one chain
	localparam int HOT_KEYS     = 48;
	localparam int RANDOM_ITEMS = 480;

	// One table operation together with the answer it must produce.
	typedef struct {
		logic [1:0]         kind;
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
		logic               found;
		logic               pool_full;
	} table_answer_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [31:0]        s_axis_tdata = '0;   // key[31:0]
	logic [1:0]         s_axis_tuser = '0;   // kind[1:0]
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [31:0]        m_axis_tdata;        // count[31:0]
	logic [1:0]         m_axis_tuser;        // found[0], pool_full[1]

	// Shadow of the table: count per stored key and the number of pool entries in use.
	logic [COUNT_W-1:0] key_tally [logic [KEY_W-1:0]];
	int unsigned        pool_used = 0;

	table_answer_t      pending_answers [$];

	logic               steady = 1'b0;      // both sides stop idling while set
	int                 stall_ask = 0;      // bumped by a test to request a hold-off
	int                 quiet_cycles = 0;
	int                 mismatch_count = 0;
	int                 beats_sent = 0;
	int                 results_checked = 0;
	int                 clears_sent = 0;

	chained_hash_count_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Updates the shadow table with one operation and returns what the block must answer.
	// An unused kind leaves the table alone and answers all zeros.
	function automatic table_answer_t predict_answer(logic [1:0] kind, logic [KEY_W-1:0] key);
		table_answer_t ans;
		ans = '{kind: kind, key: key, count: '0, found: 1'b0, pool_full: 1'b0};
		case (kind)
			KIND_CLEAR: begin
				key_tally.delete();
				pool_used = 0;
			end
			KIND_INSERT: begin
				if (key_tally.exists(key)) begin
					ans.found = 1'b1;
					if (key_tally[key] != COUNT_MAX)
						key_tally[key] = key_tally[key] + 1'b1;
					ans.count = key_tally[key];
				end else if (pool_used < ENTRIES) begin
					key_tally[key] = COUNT_W'(1);
					pool_used++;
					ans.count = COUNT_W'(1);
				end else begin
					ans.pool_full = 1'b1;
				end
			end
			KIND_QUERY: begin
				if (key_tally.exists(key)) begin
					ans.found = 1'b1;
					ans.count = key_tally[key];
				end
			end
			default: ;
		endcase
		return ans;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Offers one beat, with random idle cycles ahead of it, and records the
	// expected answer at the edge where it is accepted. Valid is left high
	// after the beat so back-to-back beats never drop it within one step.
	task automatic send_item(input logic [1:0] kind, input logic [KEY_W-1:0] key);
		if (!steady) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= key;
		s_axis_tuser  <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_answers.push_back(predict_answer(kind, key));
		beats_sent++;
		if (kind == KIND_CLEAR)
			clears_sent++;
	endtask

	// Sender goes quiet until every expected answer has come back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_answers.size() != 0);
	endtask

	task automatic check_result();
		table_answer_t want;
		if (pending_answers.size() == 0) begin
			report_mismatch($sformatf("result beat count=%0d user=%b with nothing pending",
				m_axis_tdata, m_axis_tuser));
			return;
		end
		want = pending_answers.pop_front();
		if (m_axis_tdata !== want.count)
			report_mismatch($sformatf("kind %0d key %h: count %h, want %h",
				want.kind, want.key, m_axis_tdata, want.count));
		if (m_axis_tuser[0] !== want.found)
			report_mismatch($sformatf("kind %0d key %h: found %b, want %b",
				want.kind, want.key, m_axis_tuser[0], want.found));
		if (m_axis_tuser[1] !== want.pool_full)
			report_mismatch($sformatf("kind %0d key %h: pool_full %b, want %b",
				want.kind, want.key, m_axis_tuser[1], want.pool_full));
		results_checked++;
	endtask

	// Receiver: checks each result beat and decides ready for the next cycle.
	// A hold-off request keeps ready low for a counted stretch.
	initial begin
		int stalls_served;
		int hold_left;
		stalls_served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (hold_left == 0 && stall_ask != stalls_served) begin
				stalls_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL chained_hash_count_table");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Field extremes, every kind, the most negative key, -1 against 1 in one
	// bucket, a three-deep chain in bucket zero, the ignored kind and clear.
	// Count saturation needs 2^32 inserts of one key and a full pool needs
	// ENTRIES distinct keys; both are out of reach in a run of this length.
	task automatic test_directed_corners();
		send_item(KIND_QUERY,  32'h0000_0000);
		send_item(KIND_INSERT, 32'h0000_0000);
		send_item(KIND_INSERT, 32'h0000_0000);
		send_item(KIND_QUERY,  32'h0000_0000);
		send_item(KIND_QUERY,  32'h0000_0001);
		send_item(KIND_INSERT, 32'h8000_0000);
		send_item(KIND_QUERY,  32'h8000_0000);
		send_item(KIND_INSERT, 32'h7FFF_FFFF);
		send_item(KIND_INSERT, 32'hFFFF_FFFF);
		send_item(KIND_INSERT, 32'h0000_0001);
		send_item(KIND_QUERY,  32'hFFFF_FFFF);
		send_item(KIND_QUERY,  32'h0000_0001);
		send_item(KIND_INSERT, BUCKETS);
		send_item(KIND_QUERY,  32'h0000_0000);
		send_item(KIND_UNUSED, 32'h0000_0000);
		send_item(KIND_UNUSED, 32'hFFFF_FFFF);
		send_item(KIND_QUERY,  32'h0000_0000);
		send_item(KIND_CLEAR,  32'hFFFF_FFFF);
		send_item(KIND_QUERY,  32'h0000_0000);
		send_item(KIND_INSERT, 32'h0000_0000);
		send_item(KIND_QUERY,  32'h8000_0000);
		send_item(KIND_INSERT, 32'h7FFF_FFFF);
	endtask

	// Piles keys of equal and opposite sign into one bucket, then walks to the
	// oldest entries at the tail and past the end for an absent key. Both sides
	// run without idling for the whole stretch.
	task automatic test_long_chain();
		logic [KEY_W-1:0] mag;
		steady <= 1'b1;
		send_item(KIND_CLEAR, '0);
		for (int i = 0; i < CHAIN_PAIRS; i++) begin
			mag = CHAIN_BUCKET + BUCKETS * i;
			send_item(KIND_INSERT, mag);
			send_item(KIND_INSERT, -mag);
		end
		send_item(KIND_QUERY,  CHAIN_BUCKET);
		send_item(KIND_QUERY,  -CHAIN_BUCKET);
		send_item(KIND_INSERT, CHAIN_BUCKET);
		send_item(KIND_QUERY,  CHAIN_BUCKET + BUCKETS * CHAIN_PAIRS);
		send_item(KIND_INSERT, CHAIN_BUCKET + BUCKETS * CHAIN_PAIRS);
		send_item(KIND_QUERY,  CHAIN_BUCKET + BUCKETS * CHAIN_PAIRS);
		send_item(KIND_INSERT, -(CHAIN_BUCKET + BUCKETS * (CHAIN_PAIRS - 1)));
		steady <= 1'b0;
	endtask

	// The receiver holds off while the sender keeps offering beats, so the
	// block fills and drops ready; afterwards the sender waits for everything.
	task automatic test_backpressure();
		logic [KEY_W-1:0] k;
		wait_drained();
		stall_ask <= stall_ask + 1;
		@(posedge clk);
		for (int i = 0; i < 32; i++) begin
			k = $urandom_range(0, 15);
			if ($urandom_range(0, 1))
				k = -k;
			send_item($urandom_range(0, 1) ? KIND_INSERT : KIND_QUERY, k);
		end
		wait_drained();
	endtask

	// Mostly inserts and queries over a hot set of keys, so counts climb and
	// chains grow, with random keys, same-bucket keys, rare clears and the
	// ignored kind mixed in. Ignored beats do not count toward the total.
	task automatic test_random_mix();
		logic [KEY_W-1:0] hot_keys [HOT_KEYS];
		logic [KEY_W-1:0] k;
		logic [1:0]       kind;
		int               roll;
		int               counted;
		hot_keys[0] = 32'h8000_0000;
		hot_keys[1] = 32'h7FFF_FFFF;
		hot_keys[2] = 32'hFFFF_FFFF;
		hot_keys[3] = 32'h0000_0000;
		for (int i = 4; i < HOT_KEYS; i++) begin
			case (i % 4)
				0: hot_keys[i] = $urandom_range(0, 2 * BUCKETS);
				1: hot_keys[i] = -hot_keys[i - 1];
				2: hot_keys[i] = 3 + BUCKETS * $urandom_range(0, 4000);
				default: hot_keys[i] = $urandom();
			endcase
		end
		send_item(KIND_CLEAR, $urandom());
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 2)
				kind = KIND_CLEAR;
			else if (roll < 5)
				kind = KIND_UNUSED;
			else if (roll < 52)
				kind = KIND_INSERT;
			else
				kind = KIND_QUERY;
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				k = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
			end else if (roll < 85) begin
				k = $urandom();
			end else begin
				k = $urandom_range(0, 3) + BUCKETS * $urandom_range(0, 2000);
				if ($urandom_range(0, 1))
					k = -k;
			end
			send_item(kind, k);
			if (kind != KIND_UNUSED)
				counted++;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_long_chain();
		test_backpressure();
		test_random_mix();

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_answers.size()));

		$display("Run covered %0d input beats and %0d checked results, %0d clears,",
			beats_sent, results_checked, clears_sent);
		$display("a %0d-entry chain and a long receiver stall, %0d mismatches.",
			2 * CHAIN_PAIRS, mismatch_count);
		if (mismatch_count == 0)
			$display("PASS chained_hash_count_table");
		else
			$display("FAIL chained_hash_count_table");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/chct_pkg.sv
src/chct_unit.sv
src/chct_mem.sv
src/chained_hash_count_table.sv
src/chct_checker.sv
dv/chained_hash_count_table_test.sv
